@@ hdl/psc_pkg.sv @@
// Shared constants, payload types and control structs for the centroid/spread block.
package psc_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int COORD_BITS = 20;
    localparam int IDX_BITS   = $clog2(MAX_POINTS);
    localparam int CNT_BITS   = IDX_BITS + 1;
    localparam int SUM_BITS   = COORD_BITS + IDX_BITS;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int SQ_BITS    = 2 * DIFF_BITS;
    localparam int ROOT_STEPS = (SQ_BITS + 3) / 2;
    localparam int SSQ_BITS   = 2 * ROOT_STEPS;
    localparam int ROOT_BITS  = ROOT_STEPS;
    localparam int DSUM_BITS  = ROOT_BITS + CNT_BITS;
    localparam int DCNT_BITS  = $clog2(DSUM_BITS + 1);
    localparam int DIST_BITS  = 21;
    localparam int DIST_MAX   = 2097151;
    localparam int TOTAL_BITS = 11;
    localparam int TOTAL_MAX  = 2047;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic signed [COORD_BITS-1:0] point_z;
        logic                         last_point;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] mean_x;
        logic signed [COORD_BITS-1:0] mean_y;
        logic signed [COORD_BITS-1:0] mean_z;
        logic [DIST_BITS-1:0]         mean_distance;
        logic [TOTAL_BITS-1:0]        point_total;
        logic                         overflow;
    } out_item_t;

    typedef enum logic [1:0] {
        SEL_X,
        SEL_Y,
        SEL_Z,
        SEL_D
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     idx_clr;
        logic     div_start;
        div_sel_t div_sel;
        logic     rd;
        logic     diff;
        logic     sq;
        logic     ssum;
        logic     root_start;
        logic     acc;
        logic     clear;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic root_done;
        logic idx_last;
    } sts_t;

endpackage

@@ hdl/psc_ctrl.sv @@
// Controller sequencing load, divides, per-point distance pass and result transfer.
module psc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           point_valid,
    input  logic           last_point,
    input  logic           result_stall,
    input  psc_pkg::sts_t  sts,
    output logic           point_stall,
    output logic           result_valid,
    output psc_pkg::cmd_t  cmd
);
    import psc_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD,
        S_DIVS,
        S_DIVW,
        S_RD,
        S_DIFF,
        S_SQ,
        S_SSUM,
        S_ROOTS,
        S_ROOTW,
        S_ACC,
        S_OUT
    } state_t;

    state_t   state_reg;
    div_sel_t sel_reg;
    logic     result_valid_reg;

    assign point_stall  = (state_reg != S_LOAD);
    assign result_valid = result_valid_reg;

    always_comb
    begin
        cmd         = '0;
        cmd.div_sel = sel_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                cmd.load    = point_valid;
                cmd.idx_clr = 1'b1;
            end
            S_DIVS:  cmd.div_start  = 1'b1;
            S_DIVW:  ;
            S_RD:    cmd.rd         = 1'b1;
            S_DIFF:  cmd.diff       = 1'b1;
            S_SQ:    cmd.sq         = 1'b1;
            S_SSUM:  cmd.ssum       = 1'b1;
            S_ROOTS: cmd.root_start = 1'b1;
            S_ROOTW: ;
            S_ACC:   cmd.acc        = 1'b1;
            S_OUT:   cmd.clear      = !result_stall;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_LOAD;
            sel_reg          <= SEL_X;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_LOAD:
                begin
                    if (point_valid && last_point)
                    begin
                        sel_reg   <= SEL_X;
                        state_reg <= S_DIVS;
                    end
                end
                S_DIVS: state_reg <= S_DIVW;
                S_DIVW:
                begin
                    if (sts.div_done)
                    begin
                        unique case (sel_reg)
                            SEL_X:
                            begin
                                sel_reg   <= SEL_Y;
                                state_reg <= S_DIVS;
                            end
                            SEL_Y:
                            begin
                                sel_reg   <= SEL_Z;
                                state_reg <= S_DIVS;
                            end
                            SEL_Z: state_reg <= S_RD;
                            SEL_D:
                            begin
                                result_valid_reg <= 1'b1;
                                state_reg        <= S_OUT;
                            end
                            default: state_reg <= S_LOAD;
                        endcase
                    end
                end
                S_RD:    state_reg <= S_DIFF;
                S_DIFF:  state_reg <= S_SQ;
                S_SQ:    state_reg <= S_SSUM;
                S_SSUM:  state_reg <= S_ROOTS;
                S_ROOTS: state_reg <= S_ROOTW;
                S_ROOTW:
                begin
                    if (sts.root_done)
                        state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    if (sts.idx_last)
                    begin
                        sel_reg   <= SEL_D;
                        state_reg <= S_DIVS;
                    end
                    else
                        state_reg <= S_RD;
                end
                S_OUT:
                begin
                    if (!result_stall)
                    begin
                        result_valid_reg <= 1'b0;
                        state_reg        <= S_LOAD;
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

endmodule

@@ hdl/psc_dp.sv @@
// Datapath: point store, sums, shared radix-2 divider and bit-pair square root.
module psc_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  psc_pkg::in_item_t   point,
    input  psc_pkg::cmd_t       cmd,
    output psc_pkg::sts_t       sts,
    output psc_pkg::out_item_t  result
);
    import psc_pkg::*;

    logic [3*COORD_BITS-1:0] mem [MAX_POINTS];
    logic [3*COORD_BITS-1:0] rdata_reg;

    logic signed [SUM_BITS-1:0]   sum_x_reg, sum_y_reg, sum_z_reg;
    logic [CNT_BITS-1:0]          count_reg;
    logic                         drop_reg;
    logic [IDX_BITS-1:0]          idx_reg;
    logic                         store_ok;

    logic signed [COORD_BITS-1:0] mean_x_reg, mean_y_reg, mean_z_reg;
    logic [DIST_BITS-1:0]         dist_reg;

    logic signed [DIFF_BITS-1:0]  dx_reg, dy_reg, dz_reg;
    logic signed [SQ_BITS-1:0]    sqx_reg, sqy_reg, sqz_reg;
    logic [SSQ_BITS-1:0]          ssq_reg;

    logic [SSQ_BITS-1:0]          rv_reg, rres_reg, rbit_reg;
    logic [SSQ_BITS-1:0]          rtrial;
    logic                         root_busy_reg, root_done_reg;
    logic [DSUM_BITS-1:0]         dsum_reg;

    logic [DSUM_BITS-1:0]         q_reg;
    logic [CNT_BITS-1:0]          r_reg;
    logic [CNT_BITS:0]            dtrial;
    logic [DCNT_BITS-1:0]         dcnt_reg;
    logic                         div_busy_reg, div_done_reg, neg_reg;
    div_sel_t                     dsel_reg;
    logic signed [SUM_BITS-1:0]   div_src;
    logic [SUM_BITS-1:0]          div_mag;
    logic [COORD_BITS-1:0]        q_low;
    logic [TOTAL_BITS-1:0]        total;

    assign store_ok = (count_reg < CNT_BITS'(MAX_POINTS));

    always_ff @(posedge clk)
    begin
        if (cmd.load && store_ok)
            mem[count_reg[IDX_BITS-1:0]] <= {point.point_x, point.point_y, point.point_z};
        if (cmd.rd)
            rdata_reg <= mem[idx_reg];
    end

    always_comb
    begin
        case (cmd.div_sel)
            SEL_X:   div_src = sum_x_reg;
            SEL_Y:   div_src = sum_y_reg;
            SEL_Z:   div_src = sum_z_reg;
            default: div_src = '0;
        endcase
        div_mag = div_src[SUM_BITS-1] ? SUM_BITS'(-div_src) : SUM_BITS'(div_src);
    end

    assign dtrial = {r_reg, q_reg[DSUM_BITS-1]};
    assign rtrial = rres_reg + rbit_reg;
    assign q_low  = q_reg[COORD_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            sum_z_reg     <= '0;
            count_reg     <= '0;
            drop_reg      <= 1'b0;
            idx_reg       <= '0;
            dsum_reg      <= '0;
            root_busy_reg <= 1'b0;
            root_done_reg <= 1'b0;
            div_busy_reg  <= 1'b0;
            div_done_reg  <= 1'b0;
        end
        else
        begin
            root_done_reg <= 1'b0;
            div_done_reg  <= 1'b0;

            if (cmd.load)
            begin
                if (store_ok)
                begin
                    sum_x_reg <= sum_x_reg + SUM_BITS'(point.point_x);
                    sum_y_reg <= sum_y_reg + SUM_BITS'(point.point_y);
                    sum_z_reg <= sum_z_reg + SUM_BITS'(point.point_z);
                    count_reg <= count_reg + 1'b1;
                end
                else
                    drop_reg <= 1'b1;
            end

            if (cmd.idx_clr)
                idx_reg <= '0;
            else if (cmd.acc)
                idx_reg <= idx_reg + 1'b1;

            if (cmd.acc)
                dsum_reg <= dsum_reg + DSUM_BITS'(rres_reg);

            if (cmd.clear)
            begin
                sum_x_reg <= '0;
                sum_y_reg <= '0;
                sum_z_reg <= '0;
                count_reg <= '0;
                drop_reg  <= 1'b0;
                dsum_reg  <= '0;
            end

            // square root: one result bit per cycle
            if (cmd.root_start)
                root_busy_reg <= 1'b1;
            else if (root_busy_reg && rbit_reg[0])
            begin
                root_busy_reg <= 1'b0;
                root_done_reg <= 1'b1;
            end

            // divider: one quotient bit per cycle
            if (cmd.div_start)
                div_busy_reg <= 1'b1;
            else if (div_busy_reg && dcnt_reg == DCNT_BITS'(1))
            begin
                div_busy_reg <= 1'b0;
                div_done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.diff)
        begin
            dx_reg <= DIFF_BITS'(signed'(rdata_reg[3*COORD_BITS-1:2*COORD_BITS]))
                      - DIFF_BITS'(mean_x_reg);
            dy_reg <= DIFF_BITS'(signed'(rdata_reg[2*COORD_BITS-1:COORD_BITS]))
                      - DIFF_BITS'(mean_y_reg);
            dz_reg <= DIFF_BITS'(signed'(rdata_reg[COORD_BITS-1:0])) - DIFF_BITS'(mean_z_reg);
        end
        if (cmd.sq)
        begin
            sqx_reg <= dx_reg * dx_reg;
            sqy_reg <= dy_reg * dy_reg;
            sqz_reg <= dz_reg * dz_reg;
        end
        if (cmd.ssum)
            ssq_reg <= SSQ_BITS'(unsigned'(sqx_reg)) + SSQ_BITS'(unsigned'(sqy_reg))
                       + SSQ_BITS'(unsigned'(sqz_reg));

        if (cmd.root_start)
        begin
            rv_reg   <= ssq_reg;
            rres_reg <= '0;
            rbit_reg <= SSQ_BITS'(1) << (SSQ_BITS - 2);
        end
        else if (root_busy_reg)
        begin
            if (rv_reg >= rtrial)
            begin
                rv_reg   <= rv_reg - rtrial;
                rres_reg <= (rres_reg >> 1) + rbit_reg;
            end
            else
                rres_reg <= rres_reg >> 1;
            rbit_reg <= rbit_reg >> 2;
        end

        if (cmd.div_start)
        begin
            q_reg    <= DSUM_BITS'(div_mag);
            neg_reg  <= div_src[SUM_BITS-1];
            dsel_reg <= cmd.div_sel;
            r_reg    <= '0;
            dcnt_reg <= DCNT_BITS'(DSUM_BITS);
            if (cmd.div_sel == SEL_D)
            begin
                q_reg   <= dsum_reg;
                neg_reg <= 1'b0;
            end
        end
        else if (div_busy_reg)
        begin
            if (dtrial >= {1'b0, count_reg})
            begin
                r_reg <= CNT_BITS'(dtrial - {1'b0, count_reg});
                q_reg <= {q_reg[DSUM_BITS-2:0], 1'b1};
            end
            else
            begin
                r_reg <= dtrial[CNT_BITS-1:0];
                q_reg <= {q_reg[DSUM_BITS-2:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg - 1'b1;
        end

        if (div_done_reg)
        begin
            unique case (dsel_reg)
                SEL_X: mean_x_reg <= neg_reg ? -q_low : q_low;
                SEL_Y: mean_y_reg <= neg_reg ? -q_low : q_low;
                SEL_Z: mean_z_reg <= neg_reg ? -q_low : q_low;
                SEL_D: dist_reg   <= (q_reg > DSUM_BITS'(DIST_MAX)) ? DIST_BITS'(DIST_MAX)
                                                                   : q_reg[DIST_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (32'(count_reg) > TOTAL_MAX)
            total = TOTAL_BITS'(TOTAL_MAX);
        else
            total = TOTAL_BITS'(count_reg);
    end

    assign sts.div_done  = div_done_reg;
    assign sts.root_done = root_done_reg;
    assign sts.idx_last  = ({1'b0, idx_reg} == count_reg - 1'b1);

    assign result.mean_x        = mean_x_reg;
    assign result.mean_y        = mean_y_reg;
    assign result.mean_z        = mean_z_reg;
    assign result.mean_distance = dist_reg;
    assign result.point_total   = total;
    assign result.overflow      = drop_reg;

endmodule

@@ hdl/point_set_centroid_spread.sv @@
// Points are taken one per cycle while loading; a point marked last starts the centroid/spread pass.
// After the last point: three mean divides, then a pass over each stored point (read, difference,
// square, sum, square root, accumulate), a mean-distance divide and the result output.
// Throughput: one point per cycle while loading; no points taken during the pass or
// while the result waits. Reset clears sums, count, overflow and control; store is not cleared.
module point_set_centroid_spread (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                point_valid,
    output logic                point_stall,
    input  psc_pkg::in_item_t   point,
    output logic                result_valid,
    input  logic                result_stall,
    output psc_pkg::out_item_t  result
);
    import psc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    psc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_valid),
        .last_point   (point.last_point),
        .result_stall (result_stall),
        .sts          (sts),
        .point_stall  (point_stall),
        .result_valid (result_valid),
        .cmd          (cmd)
    );

    psc_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .point  (point),
        .cmd    (cmd),
        .sts    (sts),
        .result (result)
    );

endmodule

@@ hdl/psc_checker.sv @@
// Port-level checks for the centroid/spread block, bound to the top level.
module psc_port_props (
    input logic                clk,
    input logic                rst_n,
    input logic                point_valid,
    input logic                point_stall,
    input psc_pkg::in_item_t   point,
    input logic                result_valid,
    input logic                result_stall,
    input psc_pkg::out_item_t  result
);
    import psc_pkg::*;

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    a_no_load_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> point_stall)
        else $error("points taken while result pending");

    a_stall_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && !point_stall && point.last_point |=> point_stall)
        else $error("no pass after last point");

    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.point_total != '0) &&
                         (32'(result.point_total) <= MAX_POINTS))
        else $error("point total out of range");

endmodule

bind point_set_centroid_spread psc_port_props u_psc_port_props (
    .clk          (clk),
    .rst_n        (rst_n),
    .point_valid  (point_valid),
    .point_stall  (point_stall),
    .point        (point),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

@@ verif/psc_checker.sv @@
// Checker for the centroid/spread block: predicts each set result and compares it.
`timescale 1ns / 1ps
module psc_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               point_valid,
    input  logic               point_stall,
    input  psc_pkg::in_item_t  point,
    input  logic               result_valid,
    input  logic               result_stall,
    input  psc_pkg::out_item_t result,
    output int                 errors,
    output int                 pending
);
    import psc_pkg::*;

    longint    set_x[$];
    longint    set_y[$];
    longint    set_z[$];
    logic      set_dropped;
    out_item_t expected_results[$];

    assign pending = expected_results.size();

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res;
        longint unsigned bit_w;
        res = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v)
            bit_w = bit_w >> 2;
        while (bit_w != 0)
        begin
            if (v >= res + bit_w)
            begin
                v = v - (res + bit_w);
                res = (res >> 1) + bit_w;
            end
            else
                res = res >> 1;
            bit_w = bit_w >> 2;
        end
        return res;
    endfunction

    // Centroid and mean distance of the points gathered so far.
    function automatic out_item_t centroid_spread();
        out_item_t r;
        longint sx, sy, sz, n, mx, my, mz, dx, dy, dz;
        longint unsigned dsum, md;
        sx = 0;
        sy = 0;
        sz = 0;
        dsum = 0;
        n = set_x.size();
        foreach (set_x[i])
        begin
            sx += set_x[i];
            sy += set_y[i];
            sz += set_z[i];
        end
        mx = sx / n;
        my = sy / n;
        mz = sz / n;
        foreach (set_x[i])
        begin
            dx = set_x[i] - mx;
            dy = set_y[i] - my;
            dz = set_z[i] - mz;
            dsum += root_floor(dx * dx + dy * dy + dz * dz);
        end
        md = dsum / n;
        if (md > DIST_MAX)
            md = DIST_MAX;
        r.mean_x = mx[COORD_BITS-1:0];
        r.mean_y = my[COORD_BITS-1:0];
        r.mean_z = mz[COORD_BITS-1:0];
        r.mean_distance = md[DIST_BITS-1:0];
        r.point_total = TOTAL_BITS'((n > TOTAL_MAX) ? TOTAL_MAX : n);
        r.overflow = set_dropped;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            errors <= 0;
            set_x.delete();
            set_y.delete();
            set_z.delete();
            set_dropped = 1'b0;
            expected_results.delete();
        end
        else
        begin
            if (point_valid && !point_stall)
            begin
                if (set_x.size() < MAX_POINTS)
                begin
                    set_x.push_back(longint'(point.point_x));
                    set_y.push_back(longint'(point.point_y));
                    set_z.push_back(longint'(point.point_z));
                end
                else
                    set_dropped = 1'b1;
                if (point.last_point)
                begin
                    expected_results.push_back(centroid_spread());
                    set_x.delete();
                    set_y.delete();
                    set_z.delete();
                    set_dropped = 1'b0;
                end
            end
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with none expected");
                    errors <= errors + 1;
                end
                else
                begin
                    out_item_t e;
                    int bad;
                    e = expected_results.pop_front();
                    bad = 0;
                    if (result.mean_x !== e.mean_x)
                    begin
                        $error("mean_x expected %0d got %0d", e.mean_x, result.mean_x);
                        bad++;
                    end
                    if (result.mean_y !== e.mean_y)
                    begin
                        $error("mean_y expected %0d got %0d", e.mean_y, result.mean_y);
                        bad++;
                    end
                    if (result.mean_z !== e.mean_z)
                    begin
                        $error("mean_z expected %0d got %0d", e.mean_z, result.mean_z);
                        bad++;
                    end
                    if (result.mean_distance !== e.mean_distance)
                    begin
                        $error("mean_distance expected %0d got %0d",
                               e.mean_distance, result.mean_distance);
                        bad++;
                    end
                    if (result.point_total !== e.point_total)
                    begin
                        $error("point_total expected %0d got %0d",
                               e.point_total, result.point_total);
                        bad++;
                    end
                    if (result.overflow !== e.overflow)
                    begin
                        $error("overflow expected %0d got %0d", e.overflow, result.overflow);
                        bad++;
                    end
                    errors <= errors + bad;
                end
            end
        end
    end
endmodule

@@ verif/tb_point_set_centroid_spread.sv @@
// Testbench top for the centroid/spread block: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_point_set_centroid_spread;
    import psc_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      point_valid;
    logic      point_stall;
    in_item_t  point;
    logic      result_valid;
    logic      result_stall;
    out_item_t result;
    int        errors;
    int        pending;
    bit        calm;
    int        sent;

    point_set_centroid_spread uut (.*);

    psc_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Random receiver stall, off entirely during the calm stretch.
    always @(posedge clk)
        result_stall <= calm ? 1'b0 : ($urandom_range(99) < 26);

    function automatic logic [COORD_BITS-1:0] rand_coord(int mode);
        case (mode)
            0: return {1'b1, {(COORD_BITS-1){1'b0}}};
            1: return {1'b0, {(COORD_BITS-1){1'b1}}};
            2: return COORD_BITS'($urandom_range(2047) - 1024);
            default: return COORD_BITS'($urandom);
        endcase
    endfunction

    task automatic send_point(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                              logic [COORD_BITS-1:0] z, logic last);
        while (!calm && $urandom_range(99) < 26)
        begin
            point_valid <= 1'b0;
            @(posedge clk);
        end
        point_valid <= 1'b1;
        point <= '{x, y, z, last};
        @(posedge clk);
        while (point_stall)
            @(posedge clk);
        sent++;
    endtask

    task automatic send_set(int n, int mode);
        for (int i = 0; i < n; i++)
            send_point(rand_coord(mode == 4 ? $urandom_range(3) : mode),
                       rand_coord(mode == 4 ? $urandom_range(3) : mode),
                       rand_coord(mode == 4 ? $urandom_range(3) : mode), i == n - 1);
    endtask

    initial
    begin
        rst_n = 1'b0;
        point_valid = 1'b0;
        point = '0;
        calm = 1'b0;
        sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // Directed: single points at extremes, a mixed pair, all-min and all-max triples, mixed.
        send_point(rand_coord(0), rand_coord(0), rand_coord(0), 1'b1);
        send_point(rand_coord(1), rand_coord(1), rand_coord(1), 1'b1);
        send_point(rand_coord(0), rand_coord(1), rand_coord(0), 1'b0);
        send_point(rand_coord(1), rand_coord(0), rand_coord(1), 1'b1);
        send_set(3, 0);
        send_set(3, 1);
        send_set(5, 3);
        send_point('0, '0, '0, 1'b1);
        send_point('1, '1, '1, 1'b0);
        send_point('0, '0, '0, 1'b1);
        point_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        calm = 1'b1;
        for (int s = 0; s < 30; s++)
            send_set($urandom_range(1, 6), 4);
        calm = 1'b0;
        while (sent < 650)
            send_set($urandom_range(1, 12), $urandom_range(4));
        point_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("point_set_centroid_spread: match");
        else
            $display("point_set_centroid_spread: mismatch");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("point_set_centroid_spread: mismatch");
        $finish;
    end
endmodule
